@@ hdl/rhmc_pkg.sv @@
// Shared types and constants for the rolling hash match counter.
// Holds the transaction payload structs and request codes; depends on nothing.
`timescale 1ns / 1ps

package rhmc_pkg;

    // Request codes carried in the req_type field.
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_PATTERN = 2'd1;
    localparam logic [1:0] REQ_TEXT    = 2'd2;

    // Polynomial hash base; all hash arithmetic wraps modulo 2^64.
    localparam logic [63:0] HASH_BASE = 64'd100000007;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] match_count;
        logic        pattern_overflow;
    } out_item_t;

endpackage

@@ hdl/rolling_hash_nonoverlap_match_counter_top.sv @@
// Top level of the rolling hash non-overlapping match counter.
// Depends on rhmc_pkg (types, codes, constants) and rhmc_ram (window ring).
`timescale 1ns / 1ps

//  channel | ports                    | payload             | direction
//  --------+--------------------------+---------------------+----------
//  input   | s_valid, s_ready, s_data | rhmc_pkg::in_item_t  | in
//  result  | m_valid, m_ready, m_data | rhmc_pkg::out_item_t | out
//
// One transaction is accepted per cycle in steady state. It is executed from the input
// register, and its result is loaded into the output register when it executes. The
// 64-bit rolling hash update feeds back on itself through window_hash_reg and sets the rate.
// Reset is synchronous and needs no clearing pass, since the window ring is only read after
// it has been written. A stalled result blocks execution only of a transaction that would
// produce a result.

module rolling_hash_nonoverlap_match_counter_top #(
    parameter int MAX_PAT = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rhmc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rhmc_pkg::out_item_t m_data
);

    // Ring pointer and skip counter range below MAX_PAT; lengths reach MAX_PAT.
    localparam int PTR_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
    localparam int LEN_W = $clog2(MAX_PAT + 1);

    // Input register.
    logic               in_valid_reg, in_valid_next;
    rhmc_pkg::in_item_t in_data_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    rhmc_pkg::out_item_t out_data_reg, out_data_next;

    // Query state.
    logic [63:0]      pattern_hash_reg, pattern_hash_next;
    logic [63:0]      top_weight_reg, top_weight_next;
    logic [63:0]      window_hash_reg, window_hash_next;
    logic [LEN_W-1:0] pattern_len_reg, pattern_len_next;
    logic [LEN_W-1:0] text_fill_reg, text_fill_next;
    logic [PTR_W-1:0] skip_left_reg, skip_left_next;
    logic [15:0]      count_reg, count_next;
    logic [PTR_W-1:0] ring_ptr_reg, ring_ptr_next;
    logic             overflow_reg, overflow_next;

    // Bypass for a ring entry that is written in the same cycle it is fetched.
    logic       byp_valid_reg, byp_valid_next;
    logic [7:0] byp_data_reg;

    // Ring memory signals.
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    logic             exec_emit;
    logic             exec_fire;
    logic [7:0]       leaving_byte;
    logic [LEN_W-1:0] ptr_inc;

    // A result-producing transaction waits while an older result is still held.
    assign exec_emit = (in_data_reg.req_type == rhmc_pkg::REQ_TEXT) && in_data_reg.last;
    assign exec_fire = in_valid_reg && (!exec_emit || !out_valid_reg || m_ready);

    assign s_ready = !in_valid_reg || exec_fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign leaving_byte = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign ptr_inc      = LEN_W'(ring_ptr_reg) + LEN_W'(1);

    always_comb begin
        pattern_hash_next = pattern_hash_reg;
        top_weight_next   = top_weight_reg;
        window_hash_next  = window_hash_reg;
        pattern_len_next  = pattern_len_reg;
        text_fill_next    = text_fill_reg;
        skip_left_next    = skip_left_reg;
        count_next        = count_reg;
        ring_ptr_next     = ring_ptr_reg;
        overflow_next     = overflow_reg;
        ram_we            = 1'b0;
        ram_waddr         = ring_ptr_reg;
        ram_wdata         = in_data_reg.data_byte;
        out_data_next     = out_data_reg;

        if (exec_fire) begin
            case (in_data_reg.req_type)
                rhmc_pkg::REQ_START: begin
                    pattern_hash_next = '0;
                    top_weight_next   = 64'd1;
                    window_hash_next  = '0;
                    pattern_len_next  = '0;
                    text_fill_next    = '0;
                    skip_left_next    = '0;
                    count_next        = '0;
                    ring_ptr_next     = '0;
                    overflow_next     = 1'b0;
                end
                rhmc_pkg::REQ_PATTERN: begin
                    // Pattern bytes are only taken before the first text byte.
                    if (text_fill_reg == '0) begin
                        if (pattern_len_reg < LEN_W'(MAX_PAT)) begin
                            pattern_hash_next = pattern_hash_reg * rhmc_pkg::HASH_BASE
                                              + {56'd0, in_data_reg.data_byte};
                            top_weight_next   = top_weight_reg * rhmc_pkg::HASH_BASE;
                            pattern_len_next  = pattern_len_reg + LEN_W'(1);
                        end else begin
                            overflow_next = 1'b1;
                        end
                    end
                end
                rhmc_pkg::REQ_TEXT: begin
                    if (pattern_len_reg != '0) begin
                        window_hash_next = window_hash_reg * rhmc_pkg::HASH_BASE
                            - ({56'd0, (text_fill_reg >= pattern_len_reg) ? leaving_byte
                                                                        : 8'd0}
                               * top_weight_reg)
                            + {56'd0, in_data_reg.data_byte};
                        ram_we        = 1'b1;
                        ring_ptr_next = (ptr_inc >= pattern_len_reg) ? '0 : ptr_inc[PTR_W-1:0];
                        if (text_fill_reg < pattern_len_reg) begin
                            text_fill_next = text_fill_reg + LEN_W'(1);
                        end
                        // Match test runs once the window holds a full pattern length.
                        if (text_fill_next >= pattern_len_reg) begin
                            if (skip_left_reg == '0) begin
                                if (window_hash_next == pattern_hash_reg) begin
                                    if (count_reg != rhmc_pkg::COUNT_MAX) begin
                                        count_next = count_reg + 16'd1;
                                    end
                                    skip_left_next = PTR_W'(pattern_len_reg - LEN_W'(1));
                                end
                            end else begin
                                skip_left_next = skip_left_reg - PTR_W'(1);
                            end
                        end
                    end
                    // The held result only changes when a new one is loaded.
                    if (exec_emit) begin
                        out_data_next.match_count      = count_next;
                        out_data_next.pattern_overflow = overflow_reg;
                    end
                end
                default: begin
                    // The unused request code is dropped without a result.
                end
            endcase
        end
    end

    always_comb begin
        if (exec_fire && exec_emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (exec_fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        // The ring is fetched at the pointer the next text byte uses; the read is registered.
        byp_valid_next = ram_we && (ram_waddr == ring_ptr_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pattern_hash_reg <= '0;
            top_weight_reg   <= 64'd1;
            window_hash_reg  <= '0;
            pattern_len_reg  <= '0;
            text_fill_reg    <= '0;
            skip_left_reg    <= '0;
            count_reg        <= '0;
            ring_ptr_reg     <= '0;
            overflow_reg     <= 1'b0;
            byp_valid_reg    <= 1'b0;
        end else begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            pattern_hash_reg <= pattern_hash_next;
            top_weight_reg   <= top_weight_next;
            window_hash_reg  <= window_hash_next;
            pattern_len_reg  <= pattern_len_next;
            text_fill_reg    <= text_fill_next;
            skip_left_reg    <= skip_left_next;
            count_reg        <= count_next;
            ring_ptr_reg     <= ring_ptr_next;
            overflow_reg     <= overflow_next;
            byp_valid_reg    <= byp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        out_data_reg <= out_data_next;
        byp_data_reg <= ram_wdata;
    end

    rhmc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAT)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ring_ptr_next),
        .rdata (ram_rdata)
    );

    // The ring pointer always stays inside the current window length.
    a_ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (pattern_len_reg == '0) ? (ring_ptr_reg == '0)
                                : (LEN_W'(ring_ptr_reg) < pattern_len_reg))
        else $error("ring pointer outside the window");

    // The fill level never passes the pattern length.
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        text_fill_reg <= pattern_len_reg)
        else $error("text fill exceeds pattern length");

    // Skipping only happens with a full window after a match.
    a_skip_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (skip_left_reg != '0) |-> (text_fill_reg == pattern_len_reg)
                                  && (LEN_W'(skip_left_reg) < pattern_len_reg))
        else $error("skip counter active without a full window");

    // A new result is only loaded when the previous one is gone or leaving.
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && exec_emit) |-> (!out_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule

@@ hdl/rhmc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the text window ring of the match counter.
`timescale 1ns / 1ps

module rhmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the contents before a same-cycle write.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
